// ===== rtl/pfbsdf_pkg.sv =====
// package for the font file segment deframer: item types, mode codes, constants
package pfbsdf_pkg;

    localparam int unsigned CountWidth  = 31;
    localparam int unsigned LenWidth    = 32;
    localparam int unsigned HdrIdxWidth = 3;

    localparam logic [7:0]             SEG_MARKER   = 8'h80;
    localparam logic [7:0]             SEG_TYPE_A   = 8'd1;
    localparam logic [7:0]             SEG_TYPE_B   = 8'd2;
    localparam logic [HdrIdxWidth-1:0] HDR_LAST_IDX = 3'd5;
    localparam logic [HdrIdxWidth-1:0] HDR_MARK_IDX = 3'd0;
    localparam logic [HdrIdxWidth-1:0] HDR_TYPE_IDX = 3'd1;
    localparam logic [CountWidth-1:0]  COUNT_MAX    = {CountWidth{1'b1}};

    localparam logic [1:0] PHASE_PASS    = 2'd0;
    localparam logic [1:0] PHASE_HEADER  = 2'd1;
    localparam logic [1:0] PHASE_PAYLOAD = 2'd2;
    localparam logic [1:0] PHASE_STOP    = 2'd3;

    typedef enum logic [2:0] {
        MODE_AWAIT,
        MODE_PASS,
        MODE_HEADER,
        MODE_PAYLOAD,
        MODE_STOP
    } t_mode;

    typedef struct packed {
        logic       start_of_file;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic                  keep;
        logic [7:0]            out_byte;
        logic [1:0]            phase;
        logic [CountWidth-1:0] out_count;
    } t_out_item;

endpackage

// ===== rtl/pfb_segment_deframer_core.sv =====
// Font file segment deframer: takes one byte per transfer and returns one result per byte.
// The block accepts one byte per clock while o_in_stall is low and returns one result
// per byte. All work for a byte is done combinationally by the mode machine and the
// 33-bit segment end check, ahead of an output register
// backed by a one-entry skid register, so a new byte is taken while a result still
// waits downstream. The file_length register is always ready and should be written
// only while no byte is in flight.
module pfb_segment_deframer_core
    import pfbsdf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CountWidth-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_data
);

    logic [CountWidth-1:0]  r_flen;
    t_mode                  r_mode,  n_mode;
    logic [HdrIdxWidth-1:0] r_hidx,  n_hidx;
    logic [LenWidth-1:0]    r_acc,   n_acc;
    logic [LenWidth-1:0]    r_rem,   n_rem;
    logic [CountWidth-1:0]  r_pos,   n_pos;
    logic [CountWidth-1:0]  r_cnt,   n_cnt;

    logic      r_out_valid, r_skid_valid;
    t_out_item r_out, r_skid;
    t_out_item result;

    t_mode                  base_mode, eff_mode;
    logic [HdrIdxWidth-1:0] c_hidx;
    logic [LenWidth-1:0]    c_acc, acc_new, rem_dec;
    logic [CountWidth-1:0]  c_pos, c_cnt;
    logic [LenWidth:0]      seg_end;
    logic                   hdr_ok, keep;
    logic [7:0]             b;
    logic                   in_fire, out_fire;

    assign b        = i_in_data.data_byte;
    assign in_fire  = i_in_valid && !r_skid_valid;
    assign out_fire = r_out_valid && !i_out_stall;

    // restart and first byte resolution
    always_comb begin
        base_mode = i_in_data.start_of_file ? MODE_AWAIT : r_mode;
        c_hidx    = i_in_data.start_of_file ? '0 : r_hidx;
        c_acc     = i_in_data.start_of_file ? '0 : r_acc;
        c_pos     = i_in_data.start_of_file ? '0 : r_pos;
        c_cnt     = i_in_data.start_of_file ? '0 : r_cnt;
        eff_mode  = base_mode;
        if (base_mode == MODE_AWAIT) begin
            eff_mode = (b == SEG_MARKER && r_flen != '0) ? MODE_HEADER : MODE_PASS;
        end
    end

    // header byte checks
    always_comb begin
        acc_new = c_acc;
        if (c_hidx > HDR_TYPE_IDX) begin
            acc_new = c_acc | (LenWidth'(b) << {(c_hidx - 3'd2), 3'b000});
        end
        seg_end = {2'b00, c_pos} + (LenWidth + 1)'(1) + {1'b0, acc_new};
        hdr_ok  = (c_pos < r_flen);
        case (c_hidx)
            HDR_MARK_IDX: hdr_ok = hdr_ok && (b == SEG_MARKER);
            HDR_TYPE_IDX: hdr_ok = hdr_ok && (b == SEG_TYPE_A || b == SEG_TYPE_B);
            HDR_LAST_IDX: hdr_ok = hdr_ok && (seg_end <= {2'b00, r_flen});
            default:      hdr_ok = hdr_ok;
        endcase
    end

    // next state
    always_comb begin
        n_mode  = eff_mode;
        n_hidx  = c_hidx;
        n_acc   = c_acc;
        n_rem   = i_in_data.start_of_file ? '0 : r_rem;
        rem_dec = r_rem - LenWidth'(1);
        case (eff_mode)
            MODE_PASS: n_mode = MODE_PASS;
            MODE_HEADER: begin
                if (!hdr_ok) begin
                    n_mode = MODE_STOP;
                end else if (c_hidx != HDR_LAST_IDX) begin
                    n_hidx = c_hidx + 3'd1;
                    n_acc  = acc_new;
                end else begin
                    n_rem  = acc_new;
                    n_acc  = '0;
                    n_hidx = '0;
                    n_mode = (acc_new != '0) ? MODE_PAYLOAD : MODE_HEADER;
                end
            end
            MODE_PAYLOAD: begin
                n_rem = rem_dec;
                if (rem_dec == '0) begin
                    n_mode = MODE_HEADER;
                    n_hidx = '0;
                    n_acc  = '0;
                end
            end
            default: n_mode = MODE_STOP;
        endcase
        n_cnt = (keep && c_cnt != COUNT_MAX) ? c_cnt + CountWidth'(1) : c_cnt;
        n_pos = (c_pos != COUNT_MAX) ? c_pos + CountWidth'(1) : c_pos;
    end

    // result
    always_comb begin
        keep  = 1'b0;
        result.phase = PHASE_STOP;
        case (eff_mode)
            MODE_PASS: begin
                keep         = 1'b1;
                result.phase = PHASE_PASS;
            end
            MODE_HEADER:  result.phase = hdr_ok ? PHASE_HEADER : PHASE_STOP;
            MODE_PAYLOAD: begin
                keep         = 1'b1;
                result.phase = PHASE_PAYLOAD;
            end
            default: result.phase = PHASE_STOP;
        endcase
        result.keep      = keep;
        result.out_byte  = keep ? b : 8'h00;
        result.out_count = n_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flen <= '0;
            r_mode <= MODE_AWAIT;
            r_hidx <= '0;
            r_acc  <= '0;
            r_rem  <= '0;
            r_pos  <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_flen <= i_cfg_data;
            end
            if (in_fire) begin
                r_mode <= n_mode;
                r_hidx <= n_hidx;
                r_acc  <= n_acc;
                r_rem  <= n_rem;
                r_pos  <= n_pos;
                r_cnt  <= n_cnt;
            end
        end
    end

    // output register with skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_fire || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out        <= r_skid;
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= in_fire;
                if (in_fire) begin
                    r_out <= result;
                end
            end
        end else if (in_fire) begin
            r_skid       <= result;
            r_skid_valid <= 1'b1;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== rtl/pfbsdf_checker.sv =====
// port level checks for the segment deframer and their bind to the top level
module pfbsdf_checker
    import pfbsdf_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_in_stall,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input t_out_item             o_out_data
);

    // dropped bytes carry a zero byte
    a_drop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.keep |-> o_out_data.out_byte == 8'h00)
        else $error("dropped byte not zero");

    // keep follows the phase code
    a_keep_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.keep ==
            (o_out_data.phase == PHASE_PASS || o_out_data.phase == PHASE_PAYLOAD))
        else $error("keep and phase disagree");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    // reset empties the output
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("output not empty after reset");

endmodule

bind pfb_segment_deframer_core pfbsdf_checker u_pfbsdf_checker (.*);

// ===== tb/pfb_segment_deframer_core_tb.sv =====
// self-checking testbench for the font file segment deframer core
`timescale 1ns / 100ps

module pfb_segment_deframer_core_tb;
    import pfbsdf_pkg::*;

    localparam int ByteTarget = 1125;
    localparam int CalmFrom   = 1000;
    localparam int CycleLimit = 600000;

    class deframe_scoreboard;
        t_out_item             expected_q[$];
        int                    mismatches;
        int                    config_writes;
        int                    phase_seen[4];
        logic [CountWidth-1:0] file_len;
        t_mode                 mode;
        logic [2:0]            hdr_idx;
        logic [31:0]           len_acc;
        logic [31:0]           remaining;
        logic [CountWidth-1:0] position;
        logic [CountWidth-1:0] kept;

        function new();
            file_len = '0;
            restart();
        endfunction

        function void restart();
            mode      = MODE_AWAIT;
            hdr_idx   = '0;
            len_acc   = '0;
            remaining = '0;
            position  = '0;
            kept      = '0;
        endfunction

        function void set_file_length(logic [CountWidth-1:0] value);
            file_len = value;
            config_writes++;
        endfunction

        function bit take_header(logic [7:0] b);
            logic [63:0] seg_end;
            if (position >= file_len) return 0;
            if (hdr_idx == HDR_MARK_IDX) begin
                if (b != SEG_MARKER) return 0;
            end else if (hdr_idx == HDR_TYPE_IDX) begin
                if (b != SEG_TYPE_A && b != SEG_TYPE_B) return 0;
            end else begin
                len_acc |= 32'(b) << (8 * (int'(hdr_idx) - 2));
            end
            if (hdr_idx != HDR_LAST_IDX) begin
                hdr_idx++;
                return 1;
            end
            seg_end = 64'(position) + 64'd1 + 64'(len_acc);
            if (seg_end > 64'(file_len)) return 0;
            remaining = len_acc;
            len_acc   = '0;
            hdr_idx   = '0;
            mode      = (remaining != 0) ? MODE_PAYLOAD : MODE_HEADER;
            return 1;
        endfunction

        function void note_byte(t_in_item item);
            t_out_item  res;
            logic       keep;
            logic [1:0] phase;
            if (item.start_of_file) restart();
            if (mode == MODE_AWAIT) begin
                if (item.data_byte == SEG_MARKER && file_len != 0) begin
                    mode    = MODE_HEADER;
                    hdr_idx = '0;
                    len_acc = '0;
                end else begin
                    mode = MODE_PASS;
                end
            end
            keep  = 1'b0;
            phase = PHASE_STOP;
            case (mode)
                MODE_PASS: begin
                    keep  = 1'b1;
                    phase = PHASE_PASS;
                end
                MODE_HEADER: begin
                    if (take_header(item.data_byte)) phase = PHASE_HEADER;
                    else mode = MODE_STOP;
                end
                MODE_PAYLOAD: begin
                    keep  = 1'b1;
                    phase = PHASE_PAYLOAD;
                    remaining--;
                    if (remaining == 0) begin
                        mode    = MODE_HEADER;
                        hdr_idx = '0;
                        len_acc = '0;
                    end
                end
                default: ;
            endcase
            if (keep && kept != COUNT_MAX) kept++;
            if (position != COUNT_MAX) position++;
            res.keep      = keep;
            res.out_byte  = keep ? item.data_byte : 8'h00;
            res.phase     = phase;
            res.out_count = kept;
            expected_q.push_back(res);
        endfunction

        function void flag(string what, t_out_item want, t_out_item got);
            mismatches++;
            if (mismatches <= 10) begin
                $write("%s: expected keep %0b byte %02h phase %0d count %0d, ",
                       what, want.keep, want.out_byte, want.phase, want.out_count);
                $display("got keep %0b byte %02h phase %0d count %0d",
                         got.keep, got.out_byte, got.phase, got.out_count);
            end
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (expected_q.size() == 0) begin
                flag("result with none pending", '0, got);
                return;
            end
            want = expected_q.pop_front();
            if (got.keep !== want.keep || got.out_byte !== want.out_byte ||
                got.phase !== want.phase || got.out_count !== want.out_count)
                flag("mismatch", want, got);
            else
                phase_seen[got.phase]++;
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CountWidth-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    t_in_item              in_data;
    logic                  out_valid;
    logic                  out_stall;
    t_out_item             out_data;

    deframe_scoreboard sb;
    logic [7:0]        file_q[$];
    int                hdr_pos[$];
    int                sent_bytes;
    int                files_sent;
    int                cycles;
    bit                calm;

    pfb_segment_deframer_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    initial clk = 1'b0;
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CycleLimit) begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if (cfg_valid && cfg_ready) sb.set_file_length(cfg_data);
            if (in_valid && !in_stall) sb.note_byte(in_data);
            if (out_valid && !out_stall) sb.check_result(out_data);
        end
    end

    initial begin
        out_stall = 1'b0;
        @(posedge clk);
        forever begin
            if (!calm && $urandom_range(0, 3) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            out_stall <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge clk);
        end
    end

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 5))
            0: return SEG_MARKER;
            1: return SEG_TYPE_A;
            2: return SEG_TYPE_B;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic void add_segment(logic [7:0] seg_type, logic [31:0] len, int body);
        hdr_pos.push_back(file_q.size());
        file_q.push_back(SEG_MARKER);
        file_q.push_back(seg_type);
        for (int i = 0; i < 4; i++) file_q.push_back(len[8*i +: 8]);
        for (int i = 0; i < body; i++) file_q.push_back(rand_byte());
    endfunction

    task automatic push_byte(input logic sof, input logic [7:0] b);
        if (!calm && $urandom_range(0, 9) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= {sof, b};
        do @(posedge clk); while (in_stall);
        sent_bytes++;
    endtask

    task automatic send_range(input bit with_sof, input int lo, input int hi);
        for (int i = lo; i < hi; i++) push_byte(with_sof && i == lo, file_q[i]);
    endtask

    task automatic cfg_write(input logic [CountWidth-1:0] value);
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        int                    kind;
        int                    flen;
        int                    split;
        int                    idx;
        logic [31:0]           seg_len;
        logic [CountWidth-1:0] len_cfg;
        bit                    with_sof;

        sb        = new();
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        in_data   = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // first byte without start mark while file length is still zero
        file_q = '{SEG_MARKER, 8'hFF};
        send_range(0, 0, 2);

        // zero-length segment, a real one, then a header byte past the length
        cfg_write(CountWidth'(14));
        file_q = '{SEG_MARKER, SEG_TYPE_A, 8'h00, 8'h00, 8'h00, 8'h00,
                   SEG_MARKER, SEG_TYPE_B, 8'h02, 8'h00, 8'h00, 8'h00,
                   8'hFF, 8'h00, SEG_MARKER, SEG_TYPE_A};
        send_range(1, 0, file_q.size());

        // largest length field against the largest file length
        cfg_write(COUNT_MAX);
        file_q = '{SEG_MARKER, SEG_TYPE_A, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00};
        send_range(1, 0, file_q.size());

        while (sent_bytes < ByteTarget) begin
            if (sent_bytes > CalmFrom) calm = 1'b1;
            kind = $urandom_range(0, 15);
            file_q.delete();
            hdr_pos.delete();
            if (kind < 9) begin
                repeat ($urandom_range(1, 4)) begin
                    seg_len = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 12);
                    add_segment($urandom_range(0, 1) ? SEG_TYPE_B : SEG_TYPE_A,
                                seg_len, seg_len);
                end
                flen = file_q.size();
                case ($urandom_range(0, 7))
                    0: len_cfg = CountWidth'(flen - $urandom_range(1, 6));
                    1: len_cfg = CountWidth'(flen + $urandom_range(1, 8));
                    2: len_cfg = COUNT_MAX;
                    default: len_cfg = CountWidth'(flen);
                endcase
                if ($urandom_range(0, 3) == 0)
                    repeat ($urandom_range(1, 6)) file_q.push_back(rand_byte());
            end else if (kind < 11) begin
                file_q.push_back(8'($urandom_range(0, 127)) | (8'($urandom_range(0, 1)) << 7));
                if (file_q[0] == SEG_MARKER) file_q[0] = 8'h81;
                repeat ($urandom_range(0, 29)) file_q.push_back(8'($urandom));
                len_cfg = $urandom_range(0, 1) ? CountWidth'($urandom_range(0, 40))
                                               : CountWidth'($urandom);
            end else if (kind < 13) begin
                repeat ($urandom_range(1, 3)) begin
                    seg_len = $urandom_range(0, 8);
                    add_segment(SEG_TYPE_A, seg_len, seg_len);
                end
                len_cfg = CountWidth'(file_q.size());
                idx = hdr_pos[$urandom_range(0, hdr_pos.size() - 1)];
                if ($urandom_range(0, 1)) begin
                    file_q[idx] = 8'($urandom);
                    if (file_q[idx] == SEG_MARKER) file_q[idx] = 8'h7F;
                end else begin
                    case ($urandom_range(0, 2))
                        0: file_q[idx + 1] = 8'h00;
                        1: file_q[idx + 1] = 8'h03;
                        default: file_q[idx + 1] = 8'($urandom_range(3, 255));
                    endcase
                end
            end else if (kind == 13) begin
                add_segment(SEG_TYPE_B, $urandom, $urandom_range(1, 16));
                len_cfg = $urandom_range(0, 1) ? COUNT_MAX
                                               : CountWidth'($urandom | 32'h4000_0000);
            end else begin
                file_q.push_back(SEG_MARKER);
                repeat ($urandom_range(1, 15)) file_q.push_back(rand_byte());
                len_cfg = (kind == 15) ? '0 : CountWidth'($urandom_range(1, 40));
            end

            with_sof = ($urandom_range(0, 15) != 0);
            cfg_write(len_cfg);
            if (kind < 9 && file_q.size() > 1 && $urandom_range(0, 5) == 0) begin
                // new file length lands between two bytes of the same file
                split = $urandom_range(1, file_q.size() - 1);
                send_range(with_sof, 0, split);
                cfg_write(CountWidth'(file_q.size() + $urandom_range(0, 4) - 2));
                send_range(0, split, file_q.size());
            end else begin
                send_range(with_sof, 0, file_q.size());
            end
            files_sent++;
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_q.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);

        $display("sent %0d bytes in %0d files with %0d file length writes",
                 sent_bytes, files_sent, sb.config_writes);
        $display("results by phase: passthrough %0d, header %0d, payload %0d, stopped %0d",
                 sb.phase_seen[PHASE_PASS], sb.phase_seen[PHASE_HEADER],
                 sb.phase_seen[PHASE_PAYLOAD], sb.phase_seen[PHASE_STOP]);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("%0d mismatches, %0d results never seen",
                     sb.mismatches, sb.expected_q.size());
            $display("simulation failed");
        end
        $finish;
    end

endmodule
